// ===== rtl/mcps_pkg.sv =====
// Shared types and constants for the minimum capacity partition search unit.
package mcps_pkg;

    // Fixed field widths of the words on the ports.
    localparam int WEIGHT_W = 16;
    localparam int CAP_W    = 26;
    localparam int GROUPS_W = 11;

    // Largest capacity that the result field can carry.
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    // Input word: one weight and its end-of-sequence marker.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } in_word_t;

    // Result word: the capacity found and the dropped-weight flag.
    typedef struct packed {
        logic [CAP_W-1:0] min_capacity;
        logic             overflow;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;      // store an accepted weight
        logic init_search;  // load the search bounds from max and sum
        logic start_trial;  // latch the midpoint and restart the greedy count
        logic scan_rd;      // read the next stored weight
        logic update;       // narrow the search bounds from the trial count
        logic out_load;     // capture the result word
        logic clear_seq;    // clear the per-sequence statistics
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_open;  // lower bound still below upper bound
        logic last_issue;   // the current read is the final stored weight
    } status_t;

endpackage

// ===== rtl/mcps_ctrl.sv =====
// Controller state machine that sequences loading, the binary search and the result.
module mcps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  mcps_pkg::status_t sts,
    output mcps_pkg::cmd_t    cmd
);
    import mcps_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.load_en = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init_search = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.search_open) begin
                    cmd.start_trial = 1'b1;
                    state_next      = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The final read word is folded into the count this cycle.
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load  = 1'b1;
                    cmd.clear_seq = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the word is taken.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // The search only finishes once the bounds have met.
    a_done_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !sts.search_open)
        else $error("result state reached with an open search interval");

    // A new result word only appears out of the finishing state.
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result valid raised outside the finishing state");

    // An accepted final weight always starts the search.
    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> (state_reg == ST_INIT))
        else $error("final weight accepted without starting the search");

endmodule

// ===== rtl/mcps_datapath.sv =====
// Datapath: weight memory, running sum and maximum, search bounds and greedy group count.
module mcps_datapath #(
    parameter int MAX_ITEMS   = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mcps_pkg::GROUPS_W-1:0]     cfg_wdata,
    input  mcps_pkg::in_word_t                s_word,
    output mcps_pkg::out_word_t               m_word,
    input  mcps_pkg::cmd_t                    cmd,
    output mcps_pkg::status_t                 sts
);
    import mcps_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int SUM_W  = WEIGHT_BITS + CNT_W;
    localparam int GC_W   = (CNT_W > GROUPS_W) ? CNT_W : GROUPS_W;
    localparam int EXT_W  = (SUM_W > CAP_W) ? SUM_W : CAP_W;

    // Weight memory, written while loading and read during each trial.
    logic [WEIGHT_BITS-1:0] weight_mem [MAX_ITEMS];
    logic [WEIGHT_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    logic [GROUPS_W-1:0]    max_groups_reg;
    logic [CNT_W-1:0]       item_count_reg;
    logic [SUM_W-1:0]       running_sum_reg;
    logic [WEIGHT_BITS-1:0] running_max_reg;
    logic                   dropped_reg;
    logic [SUM_W-1:0]       search_low_reg;
    logic [SUM_W-1:0]       search_high_reg;
    logic [SUM_W-1:0]       mid_reg;
    logic [SUM_W-1:0]       group_load_reg;
    logic [CNT_W-1:0]       group_count_reg;
    logic [ADDR_W-1:0]      idx_reg;
    out_word_t              m_word_reg;

    logic [WEIGHT_BITS-1:0] w_in;
    logic                   store_room;
    logic [SUM_W:0]         mid_sum;
    logic [SUM_W:0]         trial_load;
    logic [GROUPS_W-1:0]    limit;
    logic                   trial_fits;
    logic [CAP_W-1:0]       cap_sat;

    // Incoming weight trimmed or widened to the stored width.
    assign w_in       = WEIGHT_BITS'({{WEIGHT_BITS{1'b0}}, s_word.weight});
    assign store_room = item_count_reg < CNT_W'(MAX_ITEMS);

    // Midpoint of the search interval and the greedy load with the next weight.
    assign mid_sum    = {1'b0, search_low_reg} + {1'b0, search_high_reg};
    assign trial_load = {1'b0, group_load_reg} + {1'b0, SUM_W'(rd_data_reg)};

    // A group limit of zero behaves as a limit of one.
    assign limit      = (max_groups_reg == '0) ? GROUPS_W'(1) : max_groups_reg;
    assign trial_fits = GC_W'(group_count_reg) <= GC_W'(limit);

    // Result capacity clipped to the field width.
    assign cap_sat = (EXT_W'(search_low_reg) > EXT_W'(CAP_MAX)) ? CAP_MAX
                                                                 : CAP_W'(search_low_reg);

    assign sts.search_open = search_low_reg < search_high_reg;
    assign sts.last_issue  = CNT_W'(idx_reg) == (item_count_reg - CNT_W'(1));

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (cmd.load_en && store_room) begin
            weight_mem[item_count_reg[ADDR_W-1:0]] <= w_in;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_data_reg <= weight_mem[idx_reg];
        end
    end

    // Payload registers: midpoint and result word.
    always_ff @(posedge aclk) begin
        if (cmd.start_trial) begin
            mid_reg <= mid_sum[SUM_W:1];
        end
        if (cmd.out_load) begin
            m_word_reg.min_capacity <= cap_sat;
            m_word_reg.overflow     <= dropped_reg;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_groups_reg <= GROUPS_W'(1);
        end else if (cfg_we) begin
            max_groups_reg <= cfg_wdata;
        end
    end

    // Sequence statistics collected while loading.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg  <= '0;
            running_sum_reg <= '0;
            running_max_reg <= '0;
            dropped_reg     <= 1'b0;
        end else if (cmd.clear_seq) begin
            item_count_reg  <= '0;
            running_sum_reg <= '0;
            running_max_reg <= '0;
            dropped_reg     <= 1'b0;
        end else if (cmd.load_en) begin
            if (store_room) begin
                item_count_reg  <= item_count_reg + CNT_W'(1);
                running_sum_reg <= running_sum_reg + SUM_W'(w_in);
                if (w_in > running_max_reg) begin
                    running_max_reg <= w_in;
                end
            end else begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // Search bounds.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_low_reg  <= '0;
            search_high_reg <= '0;
        end else if (cmd.init_search) begin
            search_low_reg  <= SUM_W'(running_max_reg);
            search_high_reg <= running_sum_reg;
        end else if (cmd.update) begin
            if (trial_fits) begin
                search_high_reg <= mid_reg;
            end else begin
                search_low_reg <= mid_reg + SUM_W'(1);
            end
        end
    end

    // Read index and greedy group count over the stored weights.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg         <= '0;
            rd_valid_reg    <= 1'b0;
            group_load_reg  <= '0;
            group_count_reg <= CNT_W'(1);
        end else begin
            rd_valid_reg <= cmd.scan_rd;
            if (cmd.start_trial) begin
                idx_reg         <= '0;
                group_load_reg  <= '0;
                group_count_reg <= CNT_W'(1);
            end else begin
                if (cmd.scan_rd) begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                end
                if (rd_valid_reg) begin
                    if (trial_load > {1'b0, mid_reg}) begin
                        group_count_reg <= group_count_reg + CNT_W'(1);
                        group_load_reg  <= SUM_W'(rd_data_reg);
                    end else begin
                        group_load_reg <= trial_load[SUM_W-1:0];
                    end
                end
            end
        end
    end

    assign m_word = m_word_reg;

    // The interval never inverts: the answer always lies between the bounds.
    a_bounds_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        search_low_reg <= search_high_reg)
        else $error("search lower bound passed the upper bound");

endmodule

// ===== rtl/min_capacity_partition_search_unit.sv =====
// One weight word per cycle is taken while loading; after the final word a binary search runs
// between max and sum in about log2(sum - max) steps, with N = stored weights.
// Throughput is set by the one memory read port: each search step reads all N weights.
// A new sequence is accepted once the result is in the output register.
// Reset (aresetn, synchronous) clears control, statistics and bounds, max_groups to 1;
// the weight memory is not cleared, as only entries written in the current sequence are read.
module min_capacity_partition_search_unit #(
    parameter int MAX_ITEMS   = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mcps_pkg::GROUPS_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mcps_pkg::in_word_t            s_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mcps_pkg::out_word_t           m_word
);
    import mcps_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Sequencer.
    mcps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_word.last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage and arithmetic.
    mcps_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_word    (s_word),
        .m_word    (m_word),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
